// File: design/lpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_pkg
// Types and constants shared by the line position estimator.
// ----------------------------------------------------------------------------
package lpe_pkg;

  localparam int SENSOR_COUNT = 5;
  localparam int IDX_W        = $clog2(SENSOR_COUNT);
  localparam int SMP_W        = 10;
  localparam int LVL_W        = 10;
  localparam int POS_W        = 13;
  localparam int LIM_W        = 8;
  localparam int ACC_W        = 14;
  localparam int NUM_W        = 24;
  localparam int Q_W          = 13;
  localparam int DIV_STEPS    = Q_W;
  localparam int CNT_W        = $clog2(DIV_STEPS);

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_CAL   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [LVL_W-1:0] LEVEL_FULL   = 10'd1000;
  localparam logic [LVL_W-1:0] SEEN_BELOW   = 10'd800;
  localparam logic [LVL_W-1:0] WEIGHT_ABOVE = 10'd50;
  localparam logic [SMP_W-1:0] SAMPLE_MAX   = 10'd1023;
  localparam logic [POS_W-1:0] SNAP_SPLIT   = 13'd3050;
  localparam logic [POS_W-1:0] SNAP_LOW     = 13'd2500;
  localparam logic [POS_W-1:0] SNAP_HIGH    = 13'd3500;
  localparam logic [POS_W-1:0] POS_LIMIT    = 13'd5000;
  localparam logic [LIM_W-1:0] MISS_LIMIT_RST = 8'd5;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SMP_W-1:0] sample_0;
    logic [SMP_W-1:0] sample_1;
    logic [SMP_W-1:0] sample_2;
    logic [SMP_W-1:0] sample_3;
    logic [SMP_W-1:0] sample_4;
    logic             light_line;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [LVL_W-1:0] level_0;
    logic [LVL_W-1:0] level_1;
    logic [LVL_W-1:0] level_2;
    logic [LVL_W-1:0] level_3;
    logic [LVL_W-1:0] level_4;
    logic             line_seen;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_POST,
    ST_MEAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic do_load;
    logic do_step;
    logic do_post;
    logic do_mean;
    logic do_finish;
  } ctl_t;

endpackage

// File: design/line_position_estimator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_position_estimator_top
// Calibrates five reflectance sensors and estimates the line position with
// one shared restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
// Sequence: a line read loads, divides and post-processes each sensor in turn,
//   then divides once more for the weighted mean when one is formed, and finishes
//   once the output is free; clear and calibration scans act on their transfer.
// No new item is taken until a read is done: up to six divider passes plus load and post steps per sensor.
// Reset: synchronous, active low; minima to 1023, maxima to 0, position and
//   miss count to 0, miss limit to 5.
module line_position_estimator_top
  import lpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LIM_W-1:0] cfg_data
);

  state_t state_r, state_nxt;
  ctl_t   ctl;

  logic [SMP_W-1:0] low_cal_r  [SENSOR_COUNT];
  logic [SMP_W-1:0] high_cal_r [SENSOR_COUNT];
  logic [SMP_W-1:0] samp_r     [SENSOR_COUNT];
  logic [LVL_W-1:0] lvl_r      [SENSOR_COUNT];
  logic [SMP_W-1:0] in_samp    [SENSOR_COUNT];

  logic             white_r;
  logic [IDX_W-1:0] idx_r;
  logic             seen_r;
  logic             mean_r;
  logic [ACC_W-1:0] wsum_r;
  logic [Q_W-1:0]   vsum_r;
  logic [POS_W-1:0] pos_r;
  logic [LIM_W-1:0] miss_r;
  logic [LIM_W-1:0] limit_r;
  logic             lvl_zero_r;
  logic             lvl_full_r;
  logic [CNT_W-1:0] cnt_r;
  logic [Q_W-1:0]   rem_r;
  logic [Q_W-1:0]   shr_r;
  logic [Q_W-1:0]   div_r;
  logic             out_valid_r;
  out_item_t        out_item_r;

  logic             in_xfer;
  logic             out_free;
  logic             use_mean;

  logic signed [SMP_W:0] a_s, span_s;
  logic [SMP_W-1:0]      abs_a, abs_span;
  logic [NUM_W-1:0]      num_lvl, num_mean;

  logic [Q_W:0]     trial;
  logic             trial_ge;

  logic [LVL_W-1:0] lev;
  logic [LVL_W-1:0] lev_v;
  logic [IDX_W-1:0] wt;
  logic [ACC_W-1:0] wprod;

  logic [LIM_W:0]   miss_inc;
  logic [LIM_W-1:0] miss_nxt;
  logic [POS_W-1:0] pos_snap;
  logic [POS_W-1:0] pos_nxt;

  assign in_samp[0] = in_item.sample_0;
  assign in_samp[1] = in_item.sample_1;
  assign in_samp[2] = in_item.sample_2;
  assign in_samp[3] = in_item.sample_3;
  assign in_samp[4] = in_item.sample_4;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign use_mean  = seen_r && (vsum_r != '0);

  // level operands of the current sensor
  always_comb begin
    a_s      = $signed({1'b0, samp_r[idx_r]}) - $signed({1'b0, low_cal_r[idx_r]});
    span_s   = $signed({1'b0, high_cal_r[idx_r]}) - $signed({1'b0, low_cal_r[idx_r]});
    abs_a    = a_s[SMP_W] ? SMP_W'(-a_s) : a_s[SMP_W-1:0];
    abs_span = span_s[SMP_W] ? SMP_W'(-span_s) : span_s[SMP_W-1:0];
    num_lvl  = (NUM_W'(abs_a) << 10) - (NUM_W'(abs_a) << 4) - (NUM_W'(abs_a) << 3);
    num_mean = (NUM_W'(wsum_r) << 10) - (NUM_W'(wsum_r) << 4) - (NUM_W'(wsum_r) << 3);
  end

  // one restoring division step
  always_comb begin
    trial    = {rem_r, shr_r[Q_W-1]};
    trial_ge = (trial >= {1'b0, div_r});
  end

  // level post-processing and weighting
  always_comb begin
    priority if (lvl_zero_r) begin
      lev = '0;
    end else if (lvl_full_r) begin
      lev = LEVEL_FULL;
    end else begin
      lev = shr_r[LVL_W-1:0];
    end
    lev_v = white_r ? (LEVEL_FULL - lev) : lev;
    wt    = idx_r + IDX_W'(1);
    wprod = ACC_W'(lev_v) * ACC_W'(wt);
  end

  // miss counting and position
  always_comb begin
    miss_inc = {1'b0, miss_r} + (LIM_W+1)'(1);
    priority if (seen_r) begin
      miss_nxt = '0;
    end else if (miss_inc >= {1'b0, limit_r}) begin
      miss_nxt = limit_r;
    end else begin
      miss_nxt = miss_inc[LIM_W-1:0];
    end
    if (miss_nxt >= limit_r) begin
      pos_snap = (pos_r < SNAP_SPLIT) ? SNAP_LOW : SNAP_HIGH;
    end else begin
      pos_snap = pos_r;
    end
    pos_nxt = use_mean ? shr_r : pos_snap;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_item.kind == KIND_READ) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = mean_r ? ST_FINISH : ST_POST;
      end
      ST_POST: begin
        state_nxt = (idx_r == IDX_W'(SENSOR_COUNT - 1)) ? ST_MEAN : ST_LOAD;
      end
      ST_MEAN: begin
        state_nxt = use_mean ? ST_DIV : ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control decode
  always_comb begin
    ctl           = '0;
    ctl.do_load   = (state_r == ST_LOAD);
    ctl.do_step   = (state_r == ST_DIV);
    ctl.do_post   = (state_r == ST_POST);
    ctl.do_mean   = (state_r == ST_MEAN) && use_mean;
    ctl.do_finish = (state_r == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      miss_r      <= '0;
      limit_r     <= MISS_LIMIT_RST;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        low_cal_r[i]  <= SAMPLE_MAX;
        high_cal_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) limit_r <= cfg_data;

      if (in_xfer) begin
        unique case (in_item.kind)
          KIND_CLEAR: begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
              low_cal_r[i]  <= SAMPLE_MAX;
              high_cal_r[i] <= '0;
            end
          end
          KIND_CAL: begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
              if (in_samp[i] != '0 && in_samp[i] > high_cal_r[i]) high_cal_r[i] <= in_samp[i];
              if (in_samp[i] != '0 && in_samp[i] < low_cal_r[i]) low_cal_r[i] <= in_samp[i];
            end
          end
          KIND_READ: begin
            for (int i = 0; i < SENSOR_COUNT; i++) samp_r[i] <= in_samp[i];
            white_r <= in_item.light_line;
            idx_r   <= '0;
            seen_r  <= 1'b0;
            mean_r  <= 1'b0;
            wsum_r  <= '0;
            vsum_r  <= '0;
          end
          default: begin
          end
        endcase
      end

      if (ctl.do_load) begin
        lvl_zero_r <= (a_s == '0) || (span_s == '0) || (a_s[SMP_W] != span_s[SMP_W]);
        lvl_full_r <= (abs_a >= abs_span);
        div_r      <= Q_W'(abs_span);
        rem_r      <= Q_W'(num_lvl[NUM_W-1:Q_W]);
        shr_r      <= num_lvl[Q_W-1:0];
        cnt_r      <= '0;
      end

      if (ctl.do_mean) begin
        mean_r <= 1'b1;
        div_r  <= vsum_r;
        rem_r  <= Q_W'(num_mean[NUM_W-1:Q_W]);
        shr_r  <= num_mean[Q_W-1:0];
        cnt_r  <= '0;
      end

      if (ctl.do_step) begin
        rem_r <= trial_ge ? Q_W'(trial - {1'b0, div_r}) : trial[Q_W-1:0];
        shr_r <= {shr_r[Q_W-2:0], trial_ge};
        cnt_r <= cnt_r + CNT_W'(1);
      end

      if (ctl.do_post) begin
        lvl_r[idx_r] <= lev;
        if (lev_v < SEEN_BELOW) seen_r <= 1'b1;
        if (lev_v > WEIGHT_ABOVE) begin
          wsum_r <= wsum_r + wprod;
          vsum_r <= vsum_r + Q_W'(lev_v);
        end
        idx_r <= idx_r + IDX_W'(1);
      end

      if (ctl.do_finish) begin
        out_valid_r <= 1'b1;
        miss_r      <= miss_nxt;
        pos_r       <= pos_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.do_finish) begin
      out_item_r.position  <= pos_nxt;
      out_item_r.level_0   <= lvl_r[0];
      out_item_r.level_1   <= lvl_r[1];
      out_item_r.level_2   <= lvl_r[2];
      out_item_r.level_3   <= lvl_r[3];
      out_item_r.level_4   <= lvl_r[4];
      out_item_r.line_seen <= seen_r;
    end
  end

  a_rise_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside finish");

  a_level_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POST && !lvl_zero_r && !lvl_full_r) |-> (shr_r < Q_W'(LEVEL_FULL)))
    else $error("level quotient out of range");

  a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.position <= POS_LIMIT))
    else $error("position out of range");

  a_busy_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (in_stall && cnt_r < CNT_W'(DIV_STEPS)))
    else $error("divider step count out of range");

endmodule
